// ===== design/yrc_pkg.sv =====
// Shared types and constants of the YUYV to RGB converter.
package yrc_pkg;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int OUT_FRAC_BITS  = 12;

    localparam int GAIN_W = 16;
    localparam int PROD_W = 25;   // 16-bit gain times 9-bit signed offset
    localparam int ACC_W  = 27;   // sum of up to three products
    localparam int CHAN_W = 13;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_LUMA_GAIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_V_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_V_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_U_GAIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_U_GAIN  = 3'd4;

    localparam logic [CHAN_W-1:0] CHAN_FULL = CHAN_W'(64'd1 << OUT_FRAC_BITS);

    // Smallest accumulator whose rounded value exceeds full scale.
    localparam longint SAT_NUM =
        ((longint'(CHAN_FULL) + 1) * 255 <<< (GAIN_FRAC_BITS + 1))
        - (longint'(255) <<< GAIN_FRAC_BITS);
    localparam longint SAT_DEN = longint'(1) <<< (OUT_FRAC_BITS + 1);
    localparam logic signed [ACC_W-1:0] SAT_ACC =
        ACC_W'((SAT_NUM + SAT_DEN - 1) / SAT_DEN);

    // Equal fraction widths: q = floor((acc + 127) / 255), below saturation.
    localparam int M_W = 20;
    localparam logic [M_W-1:0] ROUND_BIAS = 20'd127;
    localparam int K_W = 21;
    localparam logic [K_W-1:0] RECIP_MUL = 21'h101011;  // ceil(2^28 / 255)
    localparam int RECIP_SHIFT = 28;
    localparam int RP_W = M_W + K_W;

    typedef struct packed {
        logic signed [GAIN_W-1:0] luma;
        logic signed [GAIN_W-1:0] red_v;
        logic signed [GAIN_W-1:0] green_v;
        logic signed [GAIN_W-1:0] green_u;
        logic signed [GAIN_W-1:0] blue_u;
    } t_gains;

    typedef struct packed {
        logic signed [PROD_W-1:0] red_v;
        logic signed [PROD_W-1:0] green_v;
        logic signed [PROD_W-1:0] green_u;
        logic signed [PROD_W-1:0] blue_u;
    } t_chroma;

    typedef struct packed {
        logic [CHAN_W-1:0] red_first;
        logic [CHAN_W-1:0] green_first;
        logic [CHAN_W-1:0] blue_first;
        logic [CHAN_W-1:0] red_second;
        logic [CHAN_W-1:0] green_second;
        logic [CHAN_W-1:0] blue_second;
        logic              frame_end_out;
    } t_result;

endpackage

// ===== design/yrc_chroma.sv =====
// Shared chroma products for both pixel lanes.
module yrc_chroma (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [7:0]          i_chroma_u,
    input  logic [7:0]          i_chroma_v,
    input  yrc_pkg::t_gains     i_gains,
    output yrc_pkg::t_chroma    o_prod
);

    logic signed [8:0] w_u;
    logic signed [8:0] w_v;
    yrc_pkg::t_chroma  r_prod;
    yrc_pkg::t_chroma  n_prod;

    assign w_u = $signed({1'b0, i_chroma_u}) - 9'sd128;
    assign w_v = $signed({1'b0, i_chroma_v}) - 9'sd128;

    always_comb begin
        n_prod.red_v   = yrc_pkg::PROD_W'($signed(i_gains.red_v)) * yrc_pkg::PROD_W'(w_v);
        n_prod.green_v = yrc_pkg::PROD_W'($signed(i_gains.green_v)) * yrc_pkg::PROD_W'(w_v);
        n_prod.green_u = yrc_pkg::PROD_W'($signed(i_gains.green_u)) * yrc_pkg::PROD_W'(w_u);
        n_prod.blue_u  = yrc_pkg::PROD_W'($signed(i_gains.blue_u)) * yrc_pkg::PROD_W'(w_u);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== design/yrc_scale.sv =====
// Rounds, saturates and scales one channel accumulator.
module yrc_scale (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [yrc_pkg::ACC_W-1:0]      i_acc,
    output logic        [yrc_pkg::CHAN_W-1:0]     o_q
);

    logic                         r_zero;
    logic                         r_sat;
    logic [yrc_pkg::M_W-1:0]      r_m;
    logic                         r_zero2;
    logic                         r_sat2;
    logic [yrc_pkg::RP_W-1:0]     r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero  <= i_acc[yrc_pkg::ACC_W-1] || (i_acc == '0);
            r_sat   <= (i_acc >= yrc_pkg::SAT_ACC);
            r_m     <= i_acc[yrc_pkg::M_W-1:0] + yrc_pkg::ROUND_BIAS;
            r_zero2 <= r_zero;
            r_sat2  <= r_sat;
            r_prod  <= yrc_pkg::RP_W'(r_m) * yrc_pkg::RP_W'(yrc_pkg::RECIP_MUL);
        end
    end

    always_comb begin
        priority if (r_zero2) begin
            o_q = '0;
        end else if (r_sat2) begin
            o_q = yrc_pkg::CHAN_FULL;
        end else begin
            o_q = r_prod[yrc_pkg::RECIP_SHIFT +: yrc_pkg::CHAN_W];
        end
    end

endmodule

// ===== design/yrc_lane.sv =====
// One pixel lane: luma product, channel sums and three channel scalers.
module yrc_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [7:0]                           i_luma,
    input  logic signed [yrc_pkg::GAIN_W-1:0]    i_luma_gain,
    input  yrc_pkg::t_chroma                     i_chroma,
    output logic [yrc_pkg::CHAN_W-1:0]           o_red,
    output logic [yrc_pkg::CHAN_W-1:0]           o_green,
    output logic [yrc_pkg::CHAN_W-1:0]           o_blue
);

    logic signed [8:0]                   w_c;
    logic signed [yrc_pkg::PROD_W-1:0]   w_yc;
    logic signed [yrc_pkg::PROD_W-1:0]   r_yc;
    logic signed [yrc_pkg::ACC_W-1:0]    r_acc_r;
    logic signed [yrc_pkg::ACC_W-1:0]    r_acc_g;
    logic signed [yrc_pkg::ACC_W-1:0]    r_acc_b;

    assign w_c  = $signed({1'b0, i_luma}) - 9'sd16;
    assign w_yc = yrc_pkg::PROD_W'(i_luma_gain) * yrc_pkg::PROD_W'(w_c);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yc    <= w_yc;
            r_acc_r <= yrc_pkg::ACC_W'(r_yc) + yrc_pkg::ACC_W'($signed(i_chroma.red_v));
            r_acc_g <= yrc_pkg::ACC_W'(r_yc) + yrc_pkg::ACC_W'($signed(i_chroma.green_v))
                       + yrc_pkg::ACC_W'($signed(i_chroma.green_u));
            r_acc_b <= yrc_pkg::ACC_W'(r_yc) + yrc_pkg::ACC_W'($signed(i_chroma.blue_u));
        end
    end

    yrc_scale u_scale_r (.i_clk(i_clk), .i_en(i_en), .i_acc(r_acc_r), .o_q(o_red));
    yrc_scale u_scale_g (.i_clk(i_clk), .i_en(i_en), .i_acc(r_acc_g), .o_q(o_green));
    yrc_scale u_scale_b (.i_clk(i_clk), .i_en(i_en), .i_acc(r_acc_b), .o_q(o_blue));

endmodule

// ===== design/yrc_skid.sv =====
// Output register with a spare slot; each item holds the results of both lanes.
module yrc_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  yrc_pkg::t_result   i_item,
    input  logic               i_ready,
    output logic               o_valid,
    output yrc_pkg::t_result   o_item,
    output logic               o_room
);

    logic              r_main_v;
    logic              n_main_v;
    logic              r_spare_v;
    logic              n_spare_v;
    yrc_pkg::t_result  r_main;
    yrc_pkg::t_result  n_main;
    yrc_pkg::t_result  r_spare;
    yrc_pkg::t_result  n_spare;
    logic              w_pop;

    assign w_pop = r_main_v && i_ready;

    always_comb begin
        n_main_v  = r_main_v;
        n_spare_v = r_spare_v;
        n_main    = r_main;
        n_spare   = r_spare;
        if (!r_main_v || w_pop) begin
            if (r_spare_v) begin
                n_main    = r_spare;
                n_main_v  = 1'b1;
                n_spare   = i_item;
                n_spare_v = i_push;
            end else begin
                n_main    = i_item;
                n_main_v  = i_push;
            end
        end else if (i_push) begin
            n_spare   = i_item;
            n_spare_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v  <= 1'b0;
            r_spare_v <= 1'b0;
        end else begin
            r_main_v  <= n_main_v;
            r_spare_v <= n_spare_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main  <= n_main;
        r_spare <= n_spare;
    end

    assign o_valid = r_main_v;
    assign o_item  = r_main;
    assign o_room  = !r_spare_v;

endmodule

// ===== design/yuyv_to_rgb_converter_unit.sv =====
// Top level of the YUYV 4:2:2 to RGB converter.
//
// Input channel (i_in_valid / o_in_ready) carries one macropixel per item:
// two luma bytes sharing one U and one V byte, plus a frame-end flag.
// Output channel (o_out_valid / i_out_ready) carries two RGB pixels per item,
// each channel unsigned in units of 1/4096, 0 to 4096, and the frame-end flag.
// One item is accepted every cycle while o_in_ready is high; its result moves
// through the pipeline into the output register and can be taken from there.
// Two pixel lanes each run a four-stage path: product, channel sum, bias and
// saturation test, reciprocal multiply for the divide by 255, followed by the
// output register. Chroma products are shared.
// When the receiver stalls, the result moves to a spare slot behind the
// output register; o_in_ready drops only once that slot is full, and the
// whole pipeline then holds until the output item is taken.
// Gains are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write them only while idle, as the block does not enforce it. Unknown
// indices are ignored. Reset clears the pipeline and reloads the default gains.
module yuyv_to_rgb_converter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [yrc_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [yrc_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_luma_first,
    input  logic [7:0]                    i_chroma_u,
    input  logic [7:0]                    i_luma_second,
    input  logic [7:0]                    i_chroma_v,
    input  logic                          i_frame_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [yrc_pkg::CHAN_W-1:0]    o_red_first,
    output logic [yrc_pkg::CHAN_W-1:0]    o_green_first,
    output logic [yrc_pkg::CHAN_W-1:0]    o_blue_first,
    output logic [yrc_pkg::CHAN_W-1:0]    o_red_second,
    output logic [yrc_pkg::CHAN_W-1:0]    o_green_second,
    output logic [yrc_pkg::CHAN_W-1:0]    o_blue_second,
    output logic                          o_frame_end_out
);

    yrc_pkg::t_gains   r_gains;
    yrc_pkg::t_chroma  w_chroma;
    yrc_pkg::t_result  w_push_item;
    yrc_pkg::t_result  w_out_item;
    logic [3:0]        r_vld;
    logic [3:0]        r_fe;
    logic              w_adv;
    logic              w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.luma    <= 16'sd4768;
            r_gains.red_v   <= 16'sd6537;
            r_gains.green_v <= -16'sd3330;
            r_gains.green_u <= -16'sd1602;
            r_gains.blue_u  <= 16'sd8266;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                yrc_pkg::REG_LUMA_GAIN:    r_gains.luma    <= i_cfg_data;
                yrc_pkg::REG_RED_V_GAIN:   r_gains.red_v   <= i_cfg_data;
                yrc_pkg::REG_GREEN_V_GAIN: r_gains.green_v <= i_cfg_data;
                yrc_pkg::REG_GREEN_U_GAIN: r_gains.green_u <= i_cfg_data;
                yrc_pkg::REG_BLUE_U_GAIN:  r_gains.blue_u  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv      = w_room;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fe <= {r_fe[2:0], i_frame_end};
        end
    end

    yrc_chroma u_chroma (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_chroma_u (i_chroma_u),
        .i_chroma_v (i_chroma_v),
        .i_gains    (r_gains),
        .o_prod     (w_chroma)
    );

    yrc_lane u_lane_first (
        .i_clk       (i_clk),
        .i_en        (w_adv),
        .i_luma      (i_luma_first),
        .i_luma_gain (r_gains.luma),
        .i_chroma    (w_chroma),
        .o_red       (w_push_item.red_first),
        .o_green     (w_push_item.green_first),
        .o_blue      (w_push_item.blue_first)
    );

    yrc_lane u_lane_second (
        .i_clk       (i_clk),
        .i_en        (w_adv),
        .i_luma      (i_luma_second),
        .i_luma_gain (r_gains.luma),
        .i_chroma    (w_chroma),
        .o_red       (w_push_item.red_second),
        .o_green     (w_push_item.green_second),
        .o_blue      (w_push_item.blue_second)
    );

    assign w_push_item.frame_end_out = r_fe[3];

    yrc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv && r_vld[3]),
        .i_item  (w_push_item),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (w_out_item),
        .o_room  (w_room)
    );

    assign o_red_first     = w_out_item.red_first;
    assign o_green_first   = w_out_item.green_first;
    assign o_blue_first    = w_out_item.blue_first;
    assign o_red_second    = w_out_item.red_second;
    assign o_green_second  = w_out_item.green_second;
    assign o_blue_second   = w_out_item.blue_second;
    assign o_frame_end_out = w_out_item.frame_end_out;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !o_in_ready) |=> (r_vld[3] && $stable(r_fe[3])))
        else $error("stalled item left the last pipeline stage");

    a_full_means_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_room |-> o_out_valid)
        else $error("spare slot full while output register empty");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red_first <= yrc_pkg::CHAN_FULL
                         && o_green_first <= yrc_pkg::CHAN_FULL
                         && o_blue_first <= yrc_pkg::CHAN_FULL
                         && o_red_second <= yrc_pkg::CHAN_FULL
                         && o_green_second <= yrc_pkg::CHAN_FULL
                         && o_blue_second <= yrc_pkg::CHAN_FULL))
        else $error("channel above full scale");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the YUYV 4:2:2 to RGB converter unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_u;
        logic [7:0] luma_second;
        logic [7:0] chroma_v;
        logic       frame_end;
    } t_macropixel;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [yrc_pkg::IDX_W-1:0]    i_cfg_index;
    logic [yrc_pkg::GAIN_W-1:0]   i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [7:0]                   i_luma_first;
    logic [7:0]                   i_chroma_u;
    logic [7:0]                   i_luma_second;
    logic [7:0]                   i_chroma_v;
    logic                         i_frame_end;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [yrc_pkg::CHAN_W-1:0]   o_red_first;
    logic [yrc_pkg::CHAN_W-1:0]   o_green_first;
    logic [yrc_pkg::CHAN_W-1:0]   o_blue_first;
    logic [yrc_pkg::CHAN_W-1:0]   o_red_second;
    logic [yrc_pkg::CHAN_W-1:0]   o_green_second;
    logic [yrc_pkg::CHAN_W-1:0]   o_blue_second;
    logic                         o_frame_end_out;

    yrc_pkg::t_gains   model_gains;
    yrc_pkg::t_result  expected_rgb[$];
    bit       idling_on;
    int       long_hold_requests;
    int       sent_count;
    int       results_checked = 0;
    int       mismatch_count = 0;
    int       gain_sets;
    int       long_holds = 0;
    int       stalled_cycles = 0;

    yuyv_to_rgb_converter_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_luma_first    (i_luma_first),
        .i_chroma_u      (i_chroma_u),
        .i_luma_second   (i_luma_second),
        .i_chroma_v      (i_chroma_v),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_red_first     (o_red_first),
        .o_green_first   (o_green_first),
        .o_blue_first    (o_blue_first),
        .o_red_second    (o_red_second),
        .o_green_second  (o_green_second),
        .o_blue_second   (o_blue_second),
        .o_frame_end_out (o_frame_end_out)
    );

    always #5 i_clk = ~i_clk;

    // Mostly back to back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int r;
        if (!idling_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic yrc_pkg::t_gains default_gains();
        yrc_pkg::t_gains g;
        g.luma    = 16'sd4768;
        g.red_v   = 16'sd6537;
        g.green_v = -16'sd3330;
        g.green_u = -16'sd1602;
        g.blue_u  = 16'sd8266;
        return g;
    endfunction

    function automatic yrc_pkg::t_gains uniform_gains(
        logic signed [yrc_pkg::GAIN_W-1:0] luma,
        logic signed [yrc_pkg::GAIN_W-1:0] chroma);
        yrc_pkg::t_gains g;
        g.luma    = luma;
        g.red_v   = chroma;
        g.green_v = chroma;
        g.green_u = chroma;
        g.blue_u  = chroma;
        return g;
    endfunction

    // Either anywhere in the 16-bit range or a jitter around the BT.601 set.
    function automatic yrc_pkg::t_gains random_gains(bit full_range);
        yrc_pkg::t_gains g;
        if (full_range) begin
            g.luma    = yrc_pkg::GAIN_W'($urandom_range(0, 65535));
            g.red_v   = yrc_pkg::GAIN_W'($urandom_range(0, 65535));
            g.green_v = yrc_pkg::GAIN_W'($urandom_range(0, 65535));
            g.green_u = yrc_pkg::GAIN_W'($urandom_range(0, 65535));
            g.blue_u  = yrc_pkg::GAIN_W'($urandom_range(0, 65535));
        end else begin
            g = default_gains();
            g.luma    = g.luma    + yrc_pkg::GAIN_W'($urandom_range(0, 1023)) - 16'sd512;
            g.red_v   = g.red_v   + yrc_pkg::GAIN_W'($urandom_range(0, 1023)) - 16'sd512;
            g.green_v = g.green_v + yrc_pkg::GAIN_W'($urandom_range(0, 1023)) - 16'sd512;
            g.green_u = g.green_u + yrc_pkg::GAIN_W'($urandom_range(0, 1023)) - 16'sd512;
            g.blue_u  = g.blue_u  + yrc_pkg::GAIN_W'($urandom_range(0, 1023)) - 16'sd512;
        end
        return g;
    endfunction

    function automatic t_macropixel make_macropixel(int y0, int u, int y1, int v, int fe);
        t_macropixel px;
        px.luma_first  = 8'(y0);
        px.chroma_u    = 8'(u);
        px.luma_second = 8'(y1);
        px.chroma_v    = 8'(v);
        px.frame_end   = (fe != 0);
        return px;
    endfunction

    // Half full-range bytes, half studio-range video.
    function automatic t_macropixel random_macropixel();
        t_macropixel px;
        if ($urandom_range(0, 1)) begin
            px.luma_first  = 8'($urandom_range(0, 255));
            px.chroma_u    = 8'($urandom_range(0, 255));
            px.luma_second = 8'($urandom_range(0, 255));
            px.chroma_v    = 8'($urandom_range(0, 255));
        end else begin
            px.luma_first  = 8'($urandom_range(16, 235));
            px.chroma_u    = 8'($urandom_range(96, 160));
            px.luma_second = 8'($urandom_range(16, 235));
            px.chroma_v    = 8'($urandom_range(96, 160));
        end
        px.frame_end = ($urandom_range(0, 7) == 0);
        return px;
    endfunction

    // acc / (255 * 2^GAIN_FRAC_BITS) in units of 2^-OUT_FRAC_BITS, rounded half up, clamped.
    function automatic logic [yrc_pkg::CHAN_W-1:0] scale_channel(longint acc);
        longint num, den, q, full;
        full = longint'(1) <<< yrc_pkg::OUT_FRAC_BITS;
        if (acc <= 0) return '0;
        num = acc <<< (yrc_pkg::OUT_FRAC_BITS + 1);
        den = longint'(255) <<< yrc_pkg::GAIN_FRAC_BITS;
        q   = (num + den) / (2 * den);
        if (q > full) q = full;
        return yrc_pkg::CHAN_W'(q);
    endfunction

    function automatic yrc_pkg::t_result convert_macropixel(t_macropixel px);
        yrc_pkg::t_result r;
        longint u, v, base, red_c, green_c, blue_c;
        u       = longint'(px.chroma_u) - 128;
        v       = longint'(px.chroma_v) - 128;
        red_c   = longint'(model_gains.red_v) * v;
        green_c = longint'(model_gains.green_v) * v + longint'(model_gains.green_u) * u;
        blue_c  = longint'(model_gains.blue_u) * u;
        base           = longint'(model_gains.luma) * (longint'(px.luma_first) - 16);
        r.red_first    = scale_channel(base + red_c);
        r.green_first  = scale_channel(base + green_c);
        r.blue_first   = scale_channel(base + blue_c);
        base           = longint'(model_gains.luma) * (longint'(px.luma_second) - 16);
        r.red_second   = scale_channel(base + red_c);
        r.green_second = scale_channel(base + green_c);
        r.blue_second  = scale_channel(base + blue_c);
        r.frame_end_out = px.frame_end;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge the item is taken, valid still high.
    task automatic send_macropixel(t_macropixel px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_luma_first  <= px.luma_first;
        i_chroma_u    <= px.chroma_u;
        i_luma_second <= px.luma_second;
        i_chroma_v    <= px.chroma_v;
        i_frame_end   <= px.frame_end;
        do @(posedge i_clk); while (!o_in_ready);
        expected_rgb.push_back(convert_macropixel(px));
        sent_count++;
    endtask

    task automatic send_random(int count);
        repeat (count) send_macropixel(random_macropixel());
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (expected_rgb.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [yrc_pkg::IDX_W-1:0] idx,
                             logic [yrc_pkg::GAIN_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            yrc_pkg::REG_LUMA_GAIN:    model_gains.luma    = data;
            yrc_pkg::REG_RED_V_GAIN:   model_gains.red_v   = data;
            yrc_pkg::REG_GREEN_V_GAIN: model_gains.green_v = data;
            yrc_pkg::REG_GREEN_U_GAIN: model_gains.green_u = data;
            yrc_pkg::REG_BLUE_U_GAIN:  model_gains.blue_u  = data;
            default: ;
        endcase
    endtask

    task automatic load_gains(yrc_pkg::t_gains g);
        pause_until_drained();
        write_reg(yrc_pkg::REG_LUMA_GAIN,    g.luma);
        write_reg(yrc_pkg::REG_RED_V_GAIN,   g.red_v);
        write_reg(yrc_pkg::REG_GREEN_V_GAIN, g.green_v);
        write_reg(yrc_pkg::REG_GREEN_U_GAIN, g.green_u);
        write_reg(yrc_pkg::REG_BLUE_U_GAIN,  g.blue_u);
        i_cfg_we <= 1'b0;
        gain_sets++;
    endtask

    task automatic test_reset_gains();
        send_macropixel(make_macropixel(16, 128, 16, 128, 0));    // zero accumulator
        send_macropixel(make_macropixel(235, 128, 235, 128, 0));
        send_macropixel(make_macropixel(255, 128, 255, 128, 1));  // above full scale
        send_macropixel(make_macropixel(0, 0, 0, 0, 0));
        send_macropixel(make_macropixel(255, 255, 255, 255, 1));
        send_macropixel(make_macropixel(0, 255, 255, 0, 0));
        send_macropixel(make_macropixel(255, 0, 0, 255, 1));
        send_macropixel(make_macropixel(128, 0, 128, 255, 0));
        send_macropixel(make_macropixel(128, 255, 128, 0, 0));
        send_macropixel(make_macropixel(81, 90, 81, 240, 0));
        send_macropixel(make_macropixel(16, 255, 235, 128, 1));
        send_macropixel(make_macropixel(170, 166, 41, 110, 0));
        pause_until_drained();
    endtask

    // Unit gains land right on the rounding boundary of the divide by 255.
    task automatic test_rounding();
        yrc_pkg::t_gains g;
        g = uniform_gains(16'sd1, 16'sd0);
        load_gains(g);
        send_macropixel(make_macropixel(143, 128, 144, 128, 0));
        send_macropixel(make_macropixel(15, 128, 16, 128, 1));
        send_macropixel(make_macropixel(255, 0, 0, 255, 0));
        g = uniform_gains(16'sd0, 16'sd1);
        load_gains(g);
        send_macropixel(make_macropixel(16, 255, 16, 255, 0));
        send_macropixel(make_macropixel(16, 0, 16, 0, 1));
        pause_until_drained();
    endtask

    task automatic test_gain_extremes();
        yrc_pkg::t_gains sets[6];
        sets[0] = uniform_gains(16'sh7FFF, 16'sh7FFF);
        sets[1] = uniform_gains(16'sh8000, 16'sh8000);
        sets[2] = uniform_gains(16'sh7FFF, 16'sh8000);
        sets[3] = uniform_gains(16'sh8000, 16'sh7FFF);
        sets[4] = uniform_gains(16'sd0, 16'sd0);
        sets[5] = uniform_gains(16'shFFFF, 16'sh0001);
        foreach (sets[k]) begin
            load_gains(sets[k]);
            send_macropixel(make_macropixel(255, 0, 0, 255, 1));
            send_random(11);
        end
        pause_until_drained();
    endtask

    // Writes to indices past the last gain must leave every gain alone.
    task automatic test_register_index();
        load_gains(random_gains(1'b0));
        @(posedge i_clk);
        for (int idx = int'(yrc_pkg::REG_BLUE_U_GAIN) + 1; idx < (1 << yrc_pkg::IDX_W);
             idx++)
            write_reg(yrc_pkg::IDX_W'(idx), yrc_pkg::GAIN_W'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
        send_random(20);
        pause_until_drained();
    endtask

    task automatic test_backpressure();
        load_gains(default_gains());
        idling_on = 1'b0;
        long_hold_requests++;
        send_random(64);
        pause_until_drained();
        idling_on = 1'b1;
        send_random(16);
        pause_until_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0)
                load_gains(default_gains());
            else
                load_gains(random_gains(phase % 2 == 1));
            idling_on = (phase % 3 != 2);
            send_random(60);
        end
        pause_until_drained();
        idling_on = 1'b1;
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (long_holds < long_hold_requests) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_holds++;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch at result %0d: %s", $time, results_checked, msg);
    endtask

    task automatic check_channel(string field, logic [yrc_pkg::CHAN_W-1:0] want,
                                 logic [yrc_pkg::CHAN_W-1:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    always @(posedge i_clk) begin : rgb_checker
        yrc_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rgb.size() == 0) begin
                report_mismatch("result with no macropixel outstanding");
            end else begin
                want = expected_rgb.pop_front();
                check_channel("red_first",     want.red_first,     o_red_first);
                check_channel("green_first",   want.green_first,   o_green_first);
                check_channel("blue_first",    want.blue_first,    o_blue_first);
                check_channel("red_second",    want.red_second,    o_red_second);
                check_channel("green_second",  want.green_second,  o_green_second);
                check_channel("blue_second",   want.blue_second,   o_blue_second);
                check_channel("frame_end_out", yrc_pkg::CHAN_W'(want.frame_end_out),
                              yrc_pkg::CHAN_W'(o_frame_end_out));
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_luma_first  <= '0;
        i_chroma_u    <= '0;
        i_luma_second <= '0;
        i_chroma_v    <= '0;
        i_frame_end   <= 1'b0;
        idling_on          = 1'b1;
        long_hold_requests = 0;
        sent_count         = 0;
        gain_sets          = 0;
        model_gains        = default_gains();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_gains();
        test_rounding();
        test_gain_extremes();
        test_register_index();
        test_backpressure();
        test_random_traffic();

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Converted %0d macropixels under %0d gain sets plus reset defaults,",
                 sent_count, gain_sets);
        $display("%0d results checked, %0d long receiver holds, %0d mismatches.",
                 results_checked, long_holds, mismatch_count);
        if (mismatch_count == 0 && expected_rgb.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/yrc_pkg.sv
design/yrc_chroma.sv
design/yrc_scale.sv
design/yrc_lane.sv
design/yrc_skid.sv
design/yuyv_to_rgb_converter_unit.sv
test/tb_top.sv
